@@ src/srx_pkg.sv @@
// Shared types and constants for the serial frame receiver.
// Used by all other project files; depends on nothing else.
package srx_pkg;

    // Result kinds carried on the output tuser
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_DATA  = 2'd2;
    localparam logic [1:0] EV_DONE  = 2'd3;

    // Field widths of one result word
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 12;
    localparam int unsigned FLEN_W  = 13;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned TDATA_W = 72;

    // Sequence value that forces the prior sequence to one
    localparam logic [BYTE_W-1:0] SEQ_ONE = 8'h01;

    // Reset value of the start marker register
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h7e;

    typedef struct packed {
        logic [1:0]         event_res;
        logic [INDEX_W-1:0] payload_index;
        logic [BYTE_W-1:0]  payload_byte;
        logic [BYTE_W-1:0]  frame_command;
        logic [BYTE_W-1:0]  frame_seq;
        logic [BYTE_W-1:0]  prior_seq;
        logic [FLEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0]  checksum_byte;
    } srx_result_t;

endpackage

@@ src/srx_parser.sv @@
// Frame parser state machine: header, length, payload and checksum phases.
// Depends on srx_pkg for the result struct and event codes.
module srx_parser #(
    parameter int unsigned MAX_PAYLOAD = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_accept,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          start_marker,
    output srx_pkg::srx_result_t result
);
    import srx_pkg::*;

    // Payload counter only ever reaches MAX_PAYLOAD - 1
    localparam int unsigned CNT_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned IDX_USED = (CNT_W < INDEX_W) ? CNT_W : INDEX_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_CMD   = 3'd1,
        PH_SEQ   = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CKS   = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               len_seen_reg, len_seen_next;
    logic [LEN_W-1:0]   len_acc_reg, len_acc_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BYTE_W-1:0]  cmd_reg, cmd_next;
    logic [BYTE_W-1:0]  seq_reg, seq_next;
    logic [BYTE_W-1:0]  last_seq_reg, last_seq_next;

    logic [LEN_W-1:0]   len_shift;
    logic [CNT_W:0]     count_inc;
    logic [1:0]         ev;
    logic [INDEX_W-1:0] pidx;
    logic [BYTE_W-1:0]  pbyte;
    logic [BYTE_W-1:0]  cks;

    // Shift the length accumulator by one byte, keeping 16 bits
    assign len_shift = {len_acc_reg[7:0], rx_byte};
    assign count_inc = {1'b0, count_reg} + (CNT_W+1)'(1);

    // Advance the phase for one received word
    always_comb
    begin
        phase_next    = phase_reg;
        len_seen_next = len_seen_reg;
        len_acc_next  = len_acc_reg;
        count_next    = count_reg;
        cmd_next      = cmd_reg;
        seq_next      = seq_reg;
        last_seq_next = last_seq_reg;
        ev            = EV_NONE;
        pidx          = '0;
        pbyte         = '0;
        cks           = '0;

        unique case (phase_reg)
            PH_CMD:
            begin
                cmd_next   = rx_byte;
                phase_next = PH_SEQ;
            end
            PH_SEQ:
            begin
                last_seq_next = (rx_byte == SEQ_ONE) ? SEQ_ONE : seq_reg;
                seq_next      = rx_byte;
                phase_next    = PH_LEN;
            end
            PH_LEN:
            begin
                len_acc_next = len_shift;
                if (len_seen_reg)
                begin
                    // Oversized or empty frames carry one payload byte
                    if (len_shift > MAX_LEN || len_shift == '0)
                        len_acc_next = LEN_ONE;
                    len_seen_next = 1'b0;
                    phase_next    = PH_DATA;
                end
                else
                begin
                    len_seen_next = 1'b1;
                end
            end
            PH_DATA:
            begin
                ev    = EV_DATA;
                pbyte = rx_byte;
                pidx[IDX_USED-1:0] = count_reg[IDX_USED-1:0];
                if ((LEN_W+1)'(count_inc) >= {1'b0, len_acc_reg})
                begin
                    count_next = '0;
                    phase_next = PH_CKS;
                end
                else
                begin
                    count_next = count_inc[CNT_W-1:0];
                end
            end
            PH_CKS:
            begin
                ev         = EV_DONE;
                cks        = rx_byte;
                phase_next = PH_START;
            end
            default:
            begin
                // Ignore everything up to the start marker
                phase_next = PH_START;
                if (rx_byte == start_marker)
                begin
                    ev         = EV_START;
                    phase_next = PH_CMD;
                end
            end
        endcase
    end

    // Report the state as it stands after this word
    always_comb
    begin
        result.event_res     = ev;
        result.payload_index = pidx;
        result.payload_byte  = pbyte;
        result.frame_command = cmd_next;
        result.frame_seq     = seq_next;
        result.prior_seq     = last_seq_next;
        result.frame_length  = len_acc_next[FLEN_W-1:0];
        result.checksum_byte = cks;
    end

    // Hold parser state; update only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            len_seen_reg <= 1'b0;
            len_acc_reg  <= '0;
            count_reg    <= '0;
            cmd_reg      <= '0;
            seq_reg      <= '0;
            last_seq_reg <= '0;
        end
        else if (byte_accept)
        begin
            phase_reg    <= phase_next;
            len_seen_reg <= len_seen_next;
            len_acc_reg  <= len_acc_next;
            count_reg    <= count_next;
            cmd_reg      <= cmd_next;
            seq_reg      <= seq_next;
            last_seq_reg <= last_seq_next;
        end
    end

    // Payload counter stays below the clamped length
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> {1'b0, count_reg} < (CNT_W+1)'(len_acc_reg)
                                 || len_acc_reg > LEN_W'(MAX_PAYLOAD - 1))
        else $error("payload counter reached frame length");

    // Counter is cleared whenever the payload phase is not active
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_DATA |-> count_reg == '0)
        else $error("payload counter not cleared outside payload");

    // Length is clamped to a legal value by the time payload starts
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> len_acc_reg != '0 && len_acc_reg <= MAX_LEN)
        else $error("payload length out of range");

    // Length byte flag is set only during the length phase
    assert property (@(posedge clk) disable iff (!rst_n)
        len_seen_reg |-> phase_reg == PH_LEN)
        else $error("length byte flag set outside length phase");

endmodule

@@ src/serial_frame_receiver.sv @@
// Top level of the serial frame receiver: stream ports, marker register,
// output register with skid stage. Depends on srx_pkg and srx_parser.
//
// Usage:
//   s_* carries received bytes, one word per handshake (s_tdata = rx_byte).
//   m_* carries one result word per input word: m_tuser is the event kind
//   (ignored/header, frame start, payload byte, frame complete), m_tdata the
//   frame fields. cfg_* writes the start marker; cfg_ready is always high and
//   the marker should only be changed while no word is in flight.
//   Output: the result of each byte is registered before it appears on m_*.
//   Throughput: one byte per cycle while m_tready stays high; the parser
//   updates its phase in the same cycle a byte is accepted.
//   Stall: a byte accepted while the output register is full and m_tready is
//   low parks its result in a one-word skid stage and s_tready falls on the
//   next cycle. s_tready rises again in the cycle after m_tready returns, when
//   the skid word moves to the output register.
//   Reset: the parser waits for a start marker, the marker register returns
//   to 0x7e, and both output stages are empty.
module serial_frame_receiver #(
    parameter int unsigned MAX_PAYLOAD = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // Received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Parse results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [11:0] payload_index, [19:12] payload_byte,
                                   // [27:20] frame_command, [35:28] frame_seq,
                                   // [43:36] prior_seq, [56:44] frame_length,
                                   // [64:57] checksum_byte, [71:65] zero
    output logic [1:0]  m_tuser,   // [1:0] event_res
    // Start marker write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import srx_pkg::*;

    logic              in_accept;
    logic              drain;
    srx_result_t       parse_res;
    logic [BYTE_W-1:0] marker_reg;

    logic              out_valid_reg, out_valid_next;
    srx_result_t       out_reg, out_next;
    logic              skid_valid_reg, skid_valid_next;
    srx_result_t       skid_reg, skid_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign drain     = !out_valid_reg || m_tready;

    srx_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_accept  (in_accept),
        .rx_byte      (s_tdata),
        .start_marker (marker_reg),
        .result       (parse_res)
    );

    // Hold the start marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marker_reg <= START_MARKER_RST;
        else if (cfg_valid && cfg_ready)
            marker_reg <= cfg_data;
    end

    // Move words through the output register and skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_accept)
            begin
                out_next       = parse_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            skid_next       = parse_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload stages need no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Pack the result word
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {7'd0,
                       out_reg.checksum_byte,
                       out_reg.frame_length,
                       out_reg.prior_seq,
                       out_reg.frame_seq,
                       out_reg.frame_command,
                       out_reg.payload_byte,
                       out_reg.payload_index};

    // Skid stage only fills behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word present with empty output register");

    // A stalled output with an accepted byte fills the skid stage
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready && in_accept |=> skid_valid_reg)
        else $error("accepted word lost during output stall");

    // A drained skid word moves to the output in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_tready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid word not forwarded after drain");

endmodule

@@ sim/srx_frame_checker.sv @@
// Scoreboard for the serial frame receiver: watches the byte, result and marker
// channels, predicts each result word and compares it. Depends on srx_pkg.
module srx_frame_checker #(
    parameter int unsigned MAX_PAYLOAD = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending_results,
    output int          frames_closed,
    output int          payload_words
);

    timeunit 1ns;
    timeprecision 1ps;

    import srx_pkg::*;

    typedef enum logic [2:0] {
        HUNT_MARK,
        TAKE_CMD,
        TAKE_SEQ,
        TAKE_LEN,
        TAKE_DATA,
        TAKE_CKS
    } parse_phase_t;

    // Shadow of the parser state and the marker register
    parse_phase_t       parse_phase;
    logic               len_second;
    logic [LEN_W-1:0]   len_acc;
    logic [LEN_W-1:0]   data_count;
    logic [BYTE_W-1:0]  cmd_q;
    logic [BYTE_W-1:0]  seq_q;
    logic [BYTE_W-1:0]  last_seq_q;
    logic [BYTE_W-1:0]  marker_q;

    srx_result_t expected_results[$];
    srx_result_t predicted;
    srx_result_t oldest;
    srx_result_t observed;
    int          results_seen;

    // Advance the shadow parser by one received byte and form its result word
    task automatic advance_parser(input logic [7:0] rx, output srx_result_t res);
        res = '0;
        case (parse_phase)
            TAKE_CMD:
            begin
                cmd_q       = rx;
                parse_phase = TAKE_SEQ;
            end
            TAKE_SEQ:
            begin
                last_seq_q  = (rx == SEQ_ONE) ? SEQ_ONE : seq_q;
                seq_q       = rx;
                parse_phase = TAKE_LEN;
            end
            TAKE_LEN:
            begin
                // big-endian, kept to 16 bits
                len_acc = {len_acc[7:0], rx};
                if (len_second)
                begin
                    // clamp oversized and empty frames to one payload byte
                    if (len_acc > MAX_PAYLOAD || len_acc == '0)
                        len_acc = LEN_W'(1);
                    len_second  = 1'b0;
                    parse_phase = TAKE_DATA;
                end
                else
                begin
                    len_second = 1'b1;
                end
            end
            TAKE_DATA:
            begin
                res.event_res     = EV_DATA;
                res.payload_index = data_count[INDEX_W-1:0];
                res.payload_byte  = rx;
                data_count        = data_count + 1'b1;
                if (data_count >= len_acc)
                begin
                    data_count  = '0;
                    parse_phase = TAKE_CKS;
                end
            end
            TAKE_CKS:
            begin
                res.event_res     = EV_DONE;
                res.checksum_byte = rx;
                parse_phase       = HUNT_MARK;
            end
            default:
            begin
                parse_phase = HUNT_MARK;
                if (rx == marker_q)
                begin
                    res.event_res = EV_START;
                    parse_phase   = TAKE_CMD;
                end
            end
        endcase
        res.frame_command = cmd_q;
        res.frame_seq     = seq_q;
        res.prior_seq     = last_seq_q;
        res.frame_length  = len_acc[FLEN_W-1:0];
    endtask

    function automatic string show(srx_result_t r);
        return $sformatf({"ev=%0d idx=%0d byte=%02h cmd=%02h seq=%02h",
                          " prior=%02h len=%0d cks=%02h"},
                         r.event_res, r.payload_index, r.payload_byte, r.frame_command,
                         r.frame_seq, r.prior_seq, r.frame_length, r.checksum_byte);
    endfunction

    // Track handshakes: drain results first, then predict the new byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase     = HUNT_MARK;
            len_second      = 1'b0;
            len_acc         = '0;
            data_count      = '0;
            cmd_q           = '0;
            seq_q           = '0;
            last_seq_q      = '0;
            marker_q        = START_MARKER_RST;
            expected_results.delete();
            fail_count      = 0;
            pending_results = 0;
            frames_closed   = 0;
            payload_words   = 0;
            results_seen    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                observed.event_res     = m_tuser;
                observed.payload_index = m_tdata[11:0];
                observed.payload_byte  = m_tdata[19:12];
                observed.frame_command = m_tdata[27:20];
                observed.frame_seq     = m_tdata[35:28];
                observed.prior_seq     = m_tdata[43:36];
                observed.frame_length  = m_tdata[56:44];
                observed.checksum_byte = m_tdata[64:57];
                results_seen++;
                if (m_tuser == EV_DONE)
                    frames_closed++;
                if (m_tuser == EV_DATA)
                    payload_words++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("srx_frame_checker: unexpected result word %0d: %s",
                                 results_seen, show(observed));
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (observed !== oldest || m_tdata[71:65] !== '0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("srx_frame_checker: mismatch on result word %0d",
                                     results_seen);
                            $display("  expected %s", show(oldest));
                            $display("  actual   %s pad=%02h", show(observed),
                                     m_tdata[71:65]);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                marker_q = cfg_data;
            if (s_tvalid && s_tready)
            begin
                advance_parser(s_tdata, predicted);
                expected_results.push_back(predicted);
            end
            pending_results = expected_results.size();
        end
    end

endmodule

@@ sim/tb_serial_frame_receiver.sv @@
// Testbench top for serial_frame_receiver: clock, reset, byte and marker stimulus,
// result-side back-pressure and the verdict. Depends on srx_pkg and srx_frame_checker.
module tb_serial_frame_receiver;

    timeunit 1ns;
    timeprecision 1ps;

    import srx_pkg::*;

    localparam int unsigned MAX_PAYLOAD  = 4096;
    localparam int unsigned PHASE_BYTES  = 400;
    localparam int unsigned HOLD_CYCLES  = 48;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;      // [11:0] payload_index, [19:12] payload_byte,
                               // [27:20] frame_command, [35:28] frame_seq,
                               // [43:36] prior_seq, [56:44] frame_length,
                               // [64:57] checksum_byte, [71:65] zero
    logic [1:0]  m_tuser;      // [1:0] event_res
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    int fail_count;
    int pending_results;
    int frames_closed;
    int payload_words;

    logic [7:0]  cur_marker;
    bit          burst_mode;
    bit          hold_req;
    int          bytes_sent;
    int          phase_bytes;
    int          marker_writes;
    int          long_holds;
    int          input_stalls;

    serial_frame_receiver #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    srx_frame_checker #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .frames_closed   (frames_closed),
        .payload_words   (payload_words)
    );

    // Free-running 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #10_000_000;
        $display("tb_serial_frame_receiver: done, errors");
        $finish;
    end

    // Count cycles where the block holds off an offered byte
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && !s_tready)
            input_stalls++;
    end

    function automatic int unsigned idle_cycles();
        return burst_mode ? 0 : $urandom_range(0, 3);
    endfunction

    // Random byte that can never be taken for a start marker
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == cur_marker)
            b = ~b;
        return b;
    endfunction

    // Result side: random stalls per word, plus a long hold when requested
    initial
    begin
        int unsigned n;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
                long_holds++;
            end
            n = idle_cycles();
            if (n > 0)
            begin
                m_tready = 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Offer one byte after a random gap and hold it until taken
    task automatic send_word(input logic [7:0] b);
        int unsigned n;
        n = idle_cycles();
        if (n > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        phase_bytes++;
    endtask

    // One well-formed frame; payload bytes after the first are random
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] seq,
                              input logic [15:0] len, input logic [7:0] first,
                              input logic [7:0] cks);
        int unsigned count;
        count = (len == 0 || len > MAX_PAYLOAD) ? 1 : len;
        send_word(cur_marker);
        send_word(cmd);
        send_word(seq);
        send_word(len[15:8]);
        send_word(len[7:0]);
        for (int unsigned i = 0; i < count; i++)
            send_word(i == 0 ? first : 8'($urandom_range(0, 255)));
        send_word(cks);
    endtask

    task automatic random_frame();
        logic [7:0]  seq;
        logic [15:0] len;
        int unsigned pick;
        // flip between idle and back-to-back stretches now and then
        if ($urandom_range(0, 7) == 0)
            burst_mode = !burst_mode;
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) send_word(noise_byte());
        seq  = ($urandom_range(0, 3) == 0) ? SEQ_ONE : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 4)
            len = '0;
        else if (pick < 8)
            len = 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
        else
            len = 16'($urandom_range(1, 24));
        send_frame(8'($urandom_range(0, 255)), seq, len, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    endtask

    // Release the byte channel and wait until every result has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_marker(input logic [7:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid  = 1'b0;
        cur_marker = value;
        marker_writes++;
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [7:0] markers [5];
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        cur_marker = START_MARKER_RST;
        burst_mode = 1'b0;
        hold_req   = 1'b0;
        markers    = '{8'h00, 8'hff, 8'h7e, 8'h00, 8'h5b};
        markers[3] = 8'($urandom_range(1, 254));
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: bytes before a marker, empty length, all-ones length,
        // length just past the limit, sequence of one and field extremes
        send_word(8'h00);
        send_word(8'hff);
        send_frame(8'hff, SEQ_ONE, 16'h0000, 8'ha5, 8'h00);
        send_frame(8'h00, 8'hff, 16'hffff, 8'h00, 8'hff);
        send_frame(8'h80, 8'hfe, 16'(MAX_PAYLOAD + 1), 8'hff, 8'h5a);

        // Random frames under several markers, each phase opened with a long hold
        foreach (markers[p])
        begin
            write_marker(markers[p]);
            phase_bytes = 0;
            burst_mode  = 1'b1;
            hold_req    = 1'b1;
            while (phase_bytes < PHASE_BYTES)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 8)) send_word(noise_byte());
                else
                    random_frame();
            end
        end

        drain_results();
        repeat (8) @(negedge clk);
        $display("tb_serial_frame_receiver: %0d bytes, %0d frames closed, %0d payload words",
                 bytes_sent, frames_closed, payload_words);
        $display("tb_serial_frame_receiver: %0d marker writes, %0d long holds, %0d input stalls",
                 marker_writes, long_holds, input_stalls);
        if (pending_results != 0)
            $display("tb_serial_frame_receiver: %0d result words never arrived", pending_results);
        if (fail_count == 0 && pending_results == 0)
            $display("tb_serial_frame_receiver: done, clean");
        else
            $display("tb_serial_frame_receiver: done, errors");
        $finish;
    end

endmodule
